// File: sv/assert_macros.svh
// Assertion macros included by led_scan_fold_address_unit.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequence holds in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("assertion failed");
// The consequence holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, trig, cons)
`define ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif
`endif

// File: sv/lsfa_pkg.sv
package lsfa_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ENTRY_DIRECTION = 3'd0;
    localparam logic [2:0] CFG_SCAN_ROWS       = 3'd1;
    localparam logic [2:0] CFG_ROW_FOLD        = 3'd2;
    localparam logic [2:0] CFG_COL_FOLD        = 3'd3;
    localparam logic [2:0] CFG_WIDTH_BYTES     = 3'd4;
    localparam logic [2:0] CFG_COLOR_COUNT     = 3'd5;

    // Entry direction codes: below the first one the column is mirrored,
    // above the second one the direction is invalid when folding.
    localparam logic [2:0] DIR_REVERSE_LOW = 3'd2;
    localparam logic [2:0] DIR_LAST_VALID  = 3'd3;

    // Fold divider geometry.
    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = 7;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = DIVIDEND_W / DIV_STAGES;

    // Total register stages from input to result.
    localparam int PIPE_DEPTH = DIV_STAGES + 4;

    // Payload that travels beside the divider.
    typedef struct packed {
        logic [15:0] idx;
        logic [11:0] line_len;
        logic [15:0] base;
        logic        fold_on;
        logic        bad;
        logic        rev;
    } side_t;

    // Payload after the fold row has been resolved.
    typedef struct packed {
        logic [15:0] base;
        logic [2:0]  frow;
        logic [15:0] x;
        logic [11:0] line_len;
        logic        bad;
    } tail_t;

endpackage

// File: sv/led_scan_fold_address_unit.sv
// Channel   Handshake                    Payload
// item      item_valid / item_stall      block, column, scan_line
// result    result_valid / result_stall  byte_offset, bad_direction
// config    cfg_we                       cfg_index, cfg_data
//
// Eight register stages from input to result; one item enters every cycle unless a held result stalls.
// The latency is set by the input stage, the four stages of the fold divider,
// and the fold row, row product and color product stages.
// Reset clears the valid bits and loads the register defaults.
// A stalled valid result holds the whole pipeline and raises item_stall in the same cycle.
`include "assert_macros.svh"

module led_scan_fold_address_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [4:0]  block,
    input  logic [10:0] column,
    input  logic [3:0]  scan_line,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] byte_offset,
    output logic        bad_direction
);

    localparam int LAST = lsfa_pkg::PIPE_DEPTH - 1;
    localparam int DIVO = lsfa_pkg::DIV_STAGES;

    logic [2:0] entry_direction_reg;
    logic [4:0] scan_rows_reg;
    logic [2:0] row_fold_reg;
    logic [3:0] col_fold_reg;
    logic [8:0] width_bytes_reg;
    logic [1:0] color_count_reg;

    logic               valid_reg [lsfa_pkg::PIPE_DEPTH];
    logic               advance;
    lsfa_pkg::side_t    side_reg  [lsfa_pkg::DIV_STAGES+1];
    lsfa_pkg::side_t    side_next [lsfa_pkg::DIV_STAGES+1];
    lsfa_pkg::tail_t    tail_reg;
    lsfa_pkg::tail_t    tail_next;
    logic [15:0]        m_reg;
    logic [15:0]        m_next;
    logic               m_bad_reg;
    logic [15:0]        offset_reg;
    logic [15:0]        offset_next;
    logic               bad_reg;

    logic [3:0]  rf1;
    logic [11:0] line_len_a;
    logic [6:0]  fold_len_a;
    logic [9:0]  bs_a;
    logic [15:0] div_quot;
    logic [6:0]  div_rem;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_direction_reg <= 3'd0;
            scan_rows_reg       <= 5'd16;
            row_fold_reg        <= 3'd0;
            col_fold_reg        <= 4'd0;
            width_bytes_reg     <= 9'd8;
            color_count_reg     <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsfa_pkg::CFG_ENTRY_DIRECTION: entry_direction_reg <= cfg_data[2:0];
                lsfa_pkg::CFG_SCAN_ROWS:       scan_rows_reg       <= cfg_data[4:0];
                lsfa_pkg::CFG_ROW_FOLD:        row_fold_reg        <= cfg_data[2:0];
                lsfa_pkg::CFG_COL_FOLD:        col_fold_reg        <= cfg_data[3:0];
                lsfa_pkg::CFG_WIDTH_BYTES:     width_bytes_reg     <= cfg_data[8:0];
                lsfa_pkg::CFG_COLOR_COUNT:     color_count_reg     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves unless a finished result is held back.
    assign item_stall = valid_reg[LAST] & result_stall;
    assign advance    = !item_stall;

    // Stage one: line and fold lengths, mirrored index and block row sum.
    assign rf1        = {1'b0, row_fold_reg} + 4'd1;
    assign line_len_a = {3'b0, width_bytes_reg} * {8'b0, rf1};
    assign fold_len_a = {3'b0, col_fold_reg} * {3'b0, rf1};
    assign bs_a       = {5'b0, block} * {5'b0, scan_rows_reg};

    always_comb
    begin
        side_next[0].line_len = line_len_a;
        if (entry_direction_reg < lsfa_pkg::DIR_REVERSE_LOW)
        begin
            side_next[0].idx = {4'b0, line_len_a} - 16'd1 - {5'b0, column};
        end
        else
        begin
            side_next[0].idx = {5'b0, column};
        end
        side_next[0].base    = {5'b0, ({1'b0, bs_a} + {7'b0, scan_line})};
        side_next[0].fold_on = (row_fold_reg != 3'd0) && (col_fold_reg != 4'd0);
        side_next[0].bad     = side_next[0].fold_on
                               && (entry_direction_reg > lsfa_pkg::DIR_LAST_VALID);
        side_next[0].rev     = entry_direction_reg[0];

        // Stage two scales the row sum by the fold count; later stages only carry.
        for (int s = 1; s <= lsfa_pkg::DIV_STAGES; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[1].base = side_reg[0].base * {12'b0, rf1};
    end

    // Index divided by the fold length runs beside the side payload.
    lsfa_fold_divider u_div (
        .clk       (clk),
        .advance   (advance),
        .dividend  (side_reg[0].idx),
        .divisor   (fold_len_a),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Fold row from the remainder, then the column inside the fold.
    always_comb
    begin
        logic [6:0] rem7;
        logic [6:0] sh;
        logic [2:0] fq;
        rem7 = div_rem;
        fq   = 3'd0;
        for (int k = 2; k >= 0; k--)
        begin
            sh = {3'b0, col_fold_reg} << k;
            if (rem7 >= sh)
            begin
                rem7  = rem7 - sh;
                fq[k] = 1'b1;
            end
        end
        tail_next.base     = side_reg[DIVO].base;
        tail_next.line_len = side_reg[DIVO].line_len;
        tail_next.bad      = side_reg[DIVO].bad;
        if (side_reg[DIVO].fold_on)
        begin
            tail_next.frow = side_reg[DIVO].rev ? (row_fold_reg - fq) : fq;
            tail_next.x    = div_quot * {12'b0, col_fold_reg} + {9'b0, rem7};
        end
        else
        begin
            tail_next.frow = 3'd0;
            tail_next.x    = side_reg[DIVO].idx;
        end
    end

    // Row times line length plus column, then the color plane scale, or zero for a bad direction.
    assign m_next = (tail_reg.base + {13'b0, tail_reg.frow}) * {4'b0, tail_reg.line_len}
                    + tail_reg.x;
    assign offset_next = m_bad_reg ? 16'd0 : m_reg * {14'b0, color_count_reg};

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < lsfa_pkg::PIPE_DEPTH; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= item_valid;
            for (int s = 1; s < lsfa_pkg::PIPE_DEPTH; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s <= lsfa_pkg::DIV_STAGES; s++)
            begin
                side_reg[s] <= side_next[s];
            end
            tail_reg   <= tail_next;
            m_reg      <= m_next;
            m_bad_reg  <= tail_reg.bad;
            offset_reg <= offset_next;
            bad_reg    <= m_bad_reg;
        end
    end

    assign result_valid  = valid_reg[LAST];
    assign byte_offset   = offset_reg;
    assign bad_direction = bad_reg;

    `ASSERT_SAME(a_stall_back, clk, rst_n, result_valid && result_stall, item_stall)
    `ASSERT_NEXT(a_enter, clk, rst_n, item_valid && !item_stall, valid_reg[0])
    `ASSERT_NEXT(a_exit, clk, rst_n, valid_reg[LAST-1] && advance, result_valid)
    `ASSERT_SAME(a_bad_zero, clk, rst_n, result_valid && bad_direction, byte_offset == 16'd0)

endmodule

// File: sv/lsfa_fold_divider.sv
// Pipelined restoring divider: a fixed number of quotient bits per stage.
module lsfa_fold_divider (
    input  logic                             clk,
    input  logic                             advance,
    input  logic [lsfa_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [lsfa_pkg::DIVISOR_W-1:0]   divisor,
    output logic [lsfa_pkg::DIVIDEND_W-1:0]  quotient,
    output logic [lsfa_pkg::DIVISOR_W-1:0]   remainder
);

    logic [lsfa_pkg::DIVISOR_W-1:0]  rem_reg  [lsfa_pkg::DIV_STAGES];
    logic [lsfa_pkg::DIVISOR_W-1:0]  rem_next [lsfa_pkg::DIV_STAGES];
    logic [lsfa_pkg::DIVIDEND_W-1:0] work_reg  [lsfa_pkg::DIV_STAGES];
    logic [lsfa_pkg::DIVIDEND_W-1:0] work_next [lsfa_pkg::DIV_STAGES];
    logic [lsfa_pkg::DIVISOR_W-1:0]  dvs_reg  [lsfa_pkg::DIV_STAGES];
    logic [lsfa_pkg::DIVISOR_W-1:0]  dvs_next [lsfa_pkg::DIV_STAGES];

    // Each stage shifts dividend bits into the partial remainder and
    // shifts quotient bits in at the bottom of the work word.
    always_comb
    begin
        logic [lsfa_pkg::DIVISOR_W-1:0]  r;
        logic [lsfa_pkg::DIVIDEND_W-1:0] w;
        logic [lsfa_pkg::DIVISOR_W-1:0]  d;
        logic [lsfa_pkg::DIVISOR_W:0]    trial;
        for (int s = 0; s < lsfa_pkg::DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r = '0;
                w = dividend;
                d = divisor;
            end
            else
            begin
                r = rem_reg[s-1];
                w = work_reg[s-1];
                d = dvs_reg[s-1];
            end
            for (int k = 0; k < lsfa_pkg::DIV_STEPS; k++)
            begin
                trial = {r, w[lsfa_pkg::DIVIDEND_W-1]};
                w = {w[lsfa_pkg::DIVIDEND_W-2:0], 1'b0};
                if (trial >= {1'b0, d})
                begin
                    trial = trial - {1'b0, d};
                    w[0] = 1'b1;
                end
                r = trial[lsfa_pkg::DIVISOR_W-1:0];
            end
            rem_next[s]  = r;
            work_next[s] = w;
            dvs_next[s]  = d;
        end
    end

    // Stage registers move together with the rest of the pipeline.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < lsfa_pkg::DIV_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                work_reg[s] <= work_next[s];
                dvs_reg[s]  <= dvs_next[s];
            end
        end
    end

    assign quotient  = work_reg[lsfa_pkg::DIV_STAGES-1];
    assign remainder = rem_reg[lsfa_pkg::DIV_STAGES-1];

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // Register indexes past the last register; writes there are dropped.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 12;

    // One scan byte request as it enters the block.
    typedef struct packed {
        logic [4:0]  blk;
        logic [10:0] col;
        logic [3:0]  srow;
    } scan_item_t;

    // Frame buffer address the block should produce for one item.
    typedef struct packed {
        logic [15:0] offset;
        logic        bad;
    } frame_addr_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic [4:0]  block;
    logic [10:0] column;
    logic [3:0]  scan_line;
    logic        result_valid;
    logic        result_stall;
    logic [15:0] byte_offset;
    logic        bad_direction;

    // Our copy of the panel geometry registers.
    logic [2:0]  cur_dir;
    logic [4:0]  cur_rows;
    logic [2:0]  cur_row_fold;
    logic [3:0]  cur_col_fold;
    logic [8:0]  cur_width;
    logic [1:0]  cur_colors;

    scan_item_t  scan_queue[$];
    frame_addr_t expected_addrs[$];
    scan_item_t  next_scan;
    frame_addr_t want_addr;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          error_count = 0;
    int          cycle_count = 0;
    logic        hold_go;
    logic        stall_hold;

    led_scan_fold_address_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .block         (block),
        .column        (column),
        .scan_line     (scan_line),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .byte_offset   (byte_offset),
        .bad_direction (bad_direction)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Frame buffer offset of one scan byte under the current geometry.
    function automatic frame_addr_t fold_address(input scan_item_t it);
        logic [31:0] rf1;
        logic [31:0] line_len;
        logic [31:0] base_row;
        logic [31:0] idx;
        logic [31:0] fold_len;
        logic [31:0] rem;
        logic [31:0] x;
        logic [31:0] frow;
        logic [31:0] offset;
        frame_addr_t res;
        rf1 = {29'd0, cur_row_fold} + 32'd1;
        line_len = {23'd0, cur_width} * rf1;
        base_row = {27'd0, it.blk} * {27'd0, cur_rows} * rf1 + {28'd0, it.srow} * rf1;
        idx = {21'd0, it.col};
        res.bad = 1'b0;
        // The first two directions mirror the column, as a 16-bit index.
        if (cur_dir < lsfa_pkg::DIR_REVERSE_LOW)
            idx = (line_len - 32'd1 - {21'd0, it.col}) & 32'h0000_FFFF;
        if (cur_row_fold == 3'd0 || cur_col_fold == 4'd0) begin
            offset = (base_row * line_len + idx) * {30'd0, cur_colors};
        end else if (cur_dir > lsfa_pkg::DIR_LAST_VALID) begin
            offset = 32'd0;
            res.bad = 1'b1;
        end else begin
            // Split the index into fold segments and the row inside the fold.
            fold_len = {28'd0, cur_col_fold} * rf1;
            rem = idx % fold_len;
            x = (idx / fold_len) * {28'd0, cur_col_fold} + rem % {28'd0, cur_col_fold};
            frow = rem / {28'd0, cur_col_fold};
            if (cur_dir[0])
                frow = rf1 - 32'd1 - frow;
            offset = ((base_row + frow) * line_len + x) * {30'd0, cur_colors};
        end
        res.offset = offset[15:0];
        return res;
    endfunction

    function automatic scan_item_t random_scan();
        scan_item_t it;
        int unsigned lim;
        lim = {23'd0, cur_width};
        lim = lim * ({29'd0, cur_row_fold} + 32'd1);
        if (lim > 2048)
            lim = 2048;
        it.blk = 5'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 31));
        it.srow = 4'($urandom_range(0, 15));
        // Mostly columns inside the scan line, some anywhere in the field.
        if (lim > 0 && $urandom_range(0, 99) < 85)
            it.col = 11'($urandom_range(0, lim - 1));
        else
            it.col = 11'($urandom_range(0, 2047));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] exp_val,
                                   input logic [15:0] act_val);
        error_count++;
        if (error_count <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, exp_val, act_val);
    endtask

    // Item driver: holds a stalled item, otherwise offers the next one or idles.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            block <= 5'd0;
            column <= 11'd0;
            scan_line <= 4'd0;
        end else begin
            if (item_valid && !item_stall)
                expected_addrs.push_back(fold_address(scan_item_t'({block, column, scan_line})));
            if (!item_valid || !item_stall) begin
                if (scan_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_scan = scan_queue.pop_front();
                    item_valid <= 1'b1;
                    block <= next_scan.blk;
                    column <= next_scan.col;
                    scan_line <= next_scan.srow;
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted result and picks the next stall.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall) begin
            if (expected_addrs.size() == 0) begin
                report_mismatch("unexpected result offset", 16'd0, byte_offset);
            end else begin
                want_addr = expected_addrs.pop_front();
                if (byte_offset !== want_addr.offset)
                    report_mismatch("byte_offset", want_addr.offset, byte_offset);
                if (bad_direction !== want_addr.bad)
                    report_mismatch("bad_direction", {15'd0, want_addr.bad},
                                    {15'd0, bad_direction});
            end
        end
        result_stall <= stall_hold || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Long receiver hold-off so the pipeline fills and stalls its input.
    initial
    begin
        stall_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            lsfa_pkg::CFG_ENTRY_DIRECTION: cur_dir = data[2:0];
            lsfa_pkg::CFG_SCAN_ROWS:       cur_rows = data[4:0];
            lsfa_pkg::CFG_ROW_FOLD:        cur_row_fold = data[2:0];
            lsfa_pkg::CFG_COL_FOLD:        cur_col_fold = data[3:0];
            lsfa_pkg::CFG_WIDTH_BYTES:     cur_width = data;
            lsfa_pkg::CFG_COLOR_COUNT:     cur_colors = data[1:0];
            default: ;
        endcase
    endtask

    // Loads a full geometry; the spare indexes get junk that must be ignored.
    task automatic program_setting(input logic [8:0] dir, input logic [8:0] rows,
                                   input logic [8:0] rfold, input logic [8:0] cfold,
                                   input logic [8:0] wbytes, input logic [8:0] colors);
        write_reg(lsfa_pkg::CFG_ENTRY_DIRECTION, dir);
        write_reg(lsfa_pkg::CFG_SCAN_ROWS, rows);
        write_reg(lsfa_pkg::CFG_ROW_FOLD, rfold);
        write_reg(lsfa_pkg::CFG_COL_FOLD, cfold);
        write_reg(lsfa_pkg::CFG_WIDTH_BYTES, wbytes);
        write_reg(lsfa_pkg::CFG_COLOR_COUNT, colors);
        write_reg(CFG_SPARE_LO, 9'($urandom_range(0, 511)));
        write_reg(CFG_SPARE_HI, 9'($urandom_range(0, 511)));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_random();
        logic [8:0] dir;
        logic [8:0] rows;
        logic [8:0] wbytes;
        logic [8:0] rfold;
        logic [8:0] cfold;
        dir = 9'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
                                               : $urandom_range(4, 7));
        rows = 9'(($urandom_range(0, 99) < 70) ? $urandom_range(1, 16)
                                                : $urandom_range(0, 31));
        wbytes = 9'(($urandom_range(0, 99) < 70) ? $urandom_range(1, 256)
                                                  : $urandom_range(0, 511));
        // Folding is active in most settings.
        if ($urandom_range(0, 99) < 75) begin
            rfold = 9'($urandom_range(1, 7));
            cfold = 9'($urandom_range(1, 15));
        end else begin
            rfold = 9'($urandom_range(0, 7));
            cfold = 9'($urandom_range(0, 15));
        end
        program_setting(dir, rows, rfold, cfold, wbytes, 9'($urandom_range(0, 3)));
    endtask

    task automatic push_scan(input logic [4:0] blk, input logic [10:0] col,
                             input logic [3:0] srow);
        scan_queue.push_back(scan_item_t'({blk, col, srow}));
    endtask

    // Waits until every item is sent and every result has come back.
    task automatic wait_idle();
        while (scan_queue.size() != 0 || item_valid || expected_addrs.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int unsigned send_pct,
                             input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) scan_queue.push_back(random_scan());
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lsfa_pkg::CFG_ENTRY_DIRECTION;
        cfg_data = 9'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 1'b0;
        // Register values after reset.
        cur_dir = 3'd0;
        cur_rows = 5'd16;
        cur_row_fold = 3'd0;
        cur_col_fold = 4'd0;
        cur_width = 9'd8;
        cur_colors = 2'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: mirrored columns, column past the line, block past range.
        push_scan(5'd0, 11'd0, 4'd0);
        push_scan(5'd3, 11'd7, 4'd15);
        push_scan(5'd31, 11'd2047, 4'd15);
        push_scan(5'd0, 11'd8, 4'd0);
        push_scan(5'd4, 11'd5, 4'd3);
        wait_idle();

        // Folding with mirrored columns and reversed fold rows.
        program_setting(9'd1, 9'd4, 9'd1, 9'd2, 9'd4, 9'd2);
        push_scan(5'd0, 11'd0, 4'd0);
        push_scan(5'd1, 11'd7, 4'd2);
        push_scan(5'd3, 11'd5, 4'd3);
        push_scan(5'd0, 11'd2047, 4'd1);
        wait_idle();

        // Folding with reversed fold rows only.
        program_setting(9'd3, 9'd2, 9'd3, 9'd3, 9'd6, 9'd3);
        push_scan(5'd0, 11'd0, 4'd0);
        push_scan(5'd1, 11'd23, 4'd1);
        push_scan(5'd2, 11'd11, 4'd0);
        wait_idle();

        // Folding in plain order.
        program_setting(9'd2, 9'd3, 9'd2, 9'd1, 9'd3, 9'd1);
        push_scan(5'd0, 11'd4, 4'd1);
        push_scan(5'd3, 11'd8, 4'd1);
        wait_idle();

        // Invalid direction while folding flags the error.
        program_setting(9'd5, 9'd8, 9'd1, 9'd1, 9'd10, 9'd2);
        push_scan(5'd1, 11'd3, 4'd2);
        push_scan(5'd0, 11'd0, 4'd0);
        wait_idle();

        // Invalid direction without folding is not an error.
        program_setting(9'd7, 9'd8, 9'd0, 9'd9, 9'd10, 9'd2);
        push_scan(5'd2, 11'd9, 4'd3);
        wait_idle();

        // All-zero geometry.
        program_setting(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
        push_scan(5'd1, 11'd5, 4'd2);
        wait_idle();

        // Random phases, rotating through the idling modes.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: program_setting(9'd0, 9'd16, 9'd7, 9'd15, 9'd256, 9'd3);
                1: program_setting(9'd3, 9'd31, 9'd7, 9'd15, 9'd511, 9'd3);
                2: program_setting(9'd6, 9'd5, 9'd3, 9'd4, 9'd20, 9'd2);
                3: program_setting(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
                default: program_random();
            endcase
            case (p % 4)
                0: run_phase(PHASE_ITEMS, 0, 0);
                1: run_phase(PHASE_ITEMS, 72, 0);
                2: run_phase(PHASE_ITEMS, 0, 72);
                default: run_phase(PHASE_ITEMS, 15, 15);
            endcase
        end

        // Back-pressure: receiver holds off while the sender keeps offering.
        program_random();
        hold_go = 1'b1;
        run_phase(120, 0, 0);

        repeat (lsfa_pkg::PIPE_DEPTH * 4) @(posedge clk);
        if (error_count == 0 && expected_addrs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
